FILE: rtl/scf_pkg.sv
// Shared types and constants for the spectral centroid frame block.
// No dependencies; imported by every module under rtl/.
package scf_pkg;

    localparam int FRAME_BINS = 513;
    localparam int BIN_W      = 10;
    localparam int MAG_W      = 16;
    localparam int SR_W       = 18;
    localparam int MSUM_W     = 26;
    localparam int WSUM_W     = 36;
    localparam int OUT_W      = 22;

    localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(FRAME_BINS - 1);
    localparam logic [SR_W-1:0]  SR_RESET  = SR_W'(44100);

    // Back end arithmetic
    localparam int MUL_W     = WSUM_W / 2;          // half of weighted sum per multiply
    localparam int PROD_W    = MUL_W + SR_W;
    localparam int NUM_W     = WSUM_W + SR_W;       // weighted_sum * sample_rate
    localparam int SCALE_SH  = 4;                   // 1/16 Hz units
    localparam int N_W       = NUM_W + SCALE_SH;
    localparam int DEN_W     = N_W - OUT_W;
    localparam int DCNT_W    = $clog2(OUT_W);

    // Frame queue
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [WSUM_W-1:0] wsum;
        logic [MSUM_W-1:0] msum;
        logic [SR_W-1:0]   sr;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_SUM,
        B_DIV,
        B_DONE
    } t_bstate;

endpackage

FILE: rtl/scf_front.sv
// Front end: takes bins, accumulates magnitude and weighted sums, holds sample rate.
// Depends on scf_pkg; pushes finished frame sums into scf_fifo.
module scf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [scf_pkg::MAG_W-1:0] i_magnitude,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [scf_pkg::SR_W-1:0]  i_cfg_data,
    input  scf_pkg::t_q_status        i_q_status,
    output logic                      o_push,
    output scf_pkg::t_frame           o_frame
);
    import scf_pkg::*;

    logic [BIN_W-1:0]       r_bin;
    logic [MSUM_W-1:0]      r_msum;
    logic [WSUM_W-1:0]      r_wsum;
    logic [SR_W-1:0]        r_sr;
    logic [MSUM_W-1:0]      n_msum;
    logic [WSUM_W-1:0]      n_wsum;
    logic [BIN_W+MAG_W-1:0] w_prod;
    logic                   w_accept;
    logic                   w_last;

    assign o_in_stall  = i_q_status.full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid & ~i_q_status.full;
    assign w_last      = (r_bin == LAST_BIN);

    assign w_prod = r_bin * i_magnitude;
    assign n_msum = r_msum + MSUM_W'(i_magnitude);
    assign n_wsum = r_wsum + WSUM_W'(w_prod);

    assign o_push       = w_accept & w_last;
    assign o_frame.wsum = n_wsum;
    assign o_frame.msum = n_msum;
    assign o_frame.sr   = r_sr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin  <= '0;
            r_msum <= '0;
            r_wsum <= '0;
            r_sr   <= SR_RESET;
        end else begin
            if (w_accept) begin
                if (w_last) begin
                    r_bin  <= '0;
                    r_msum <= '0;
                    r_wsum <= '0;
                end else begin
                    r_bin  <= r_bin + BIN_W'(1);
                    r_msum <= n_msum;
                    r_wsum <= n_wsum;
                end
            end
            if (i_cfg_valid) begin
                r_sr <= i_cfg_data;
            end
        end
    end

endmodule

FILE: rtl/scf_fifo.sv
// Short queue of finished frame sums between front and back end.
// Depends on scf_pkg for the frame word type and depth.
module scf_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  scf_pkg::t_frame    i_wdata,
    input  logic               i_pop,
    output scf_pkg::t_frame    o_rdata,
    output scf_pkg::t_q_status o_status
);
    import scf_pkg::*;

    t_frame            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [FCNT_W-1:0] r_cnt;

    assign o_rdata        = r_mem[r_rp];
    assign o_status.full  = (r_cnt == FCNT_W'(FIFO_DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + FCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - FCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/scf_back.sv
// Back end: scales one frame's sums and divides them bit by bit into the centroid.
// Depends on scf_pkg; pops frames from scf_fifo and owns the output register.
module scf_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  scf_pkg::t_frame           i_frame,
    input  scf_pkg::t_q_status        i_q_status,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [scf_pkg::OUT_W-1:0] o_centroid_hz
);
    import scf_pkg::*;

    t_bstate           r_state;
    t_bstate           n_state;
    logic [WSUM_W-1:0] r_ws;
    logic [SR_W-1:0]   r_sr;
    logic [DEN_W-1:0]  r_den;
    logic [PROD_W-1:0] r_plo;
    logic [PROD_W-1:0] r_phi;
    logic [DEN_W-1:0]  r_rem;
    logic [OUT_W-1:0]  r_nlo;
    logic [OUT_W-1:0]  r_q;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out;

    logic [MUL_W-1:0]  w_mul_a;
    logic [PROD_W-1:0] w_prod;
    logic [NUM_W-1:0]  w_num;
    logic [N_W-1:0]    w_n;
    logic [DEN_W:0]    w_rem_sh;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;
    logic              w_div_last;
    logic              w_out_free;

    // One shared multiplier: low half of weighted sum, then high half
    assign w_mul_a = (r_state == B_MUL_LO) ? r_ws[MUL_W-1:0] : r_ws[WSUM_W-1:MUL_W];
    assign w_prod  = w_mul_a * r_sr;

    assign w_num = {r_phi, {MUL_W{1'b0}}} + NUM_W'(r_plo);
    assign w_n   = {w_num, {SCALE_SH{1'b0}}};

    // Restoring division step: quotient fits OUT_W bits, so top part starts below divisor
    assign w_rem_sh = {r_rem, r_nlo[OUT_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    assign w_div_last = (r_cnt == DCNT_W'(OUT_W - 1));
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    assign o_pop         = (r_state == B_IDLE) & ~i_q_status.empty;
    assign o_out_valid   = r_out_valid;
    assign o_centroid_hz = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) n_state = B_MUL_LO;
            end
            B_MUL_LO: n_state = B_MUL_HI;
            B_MUL_HI: n_state = B_SUM;
            B_SUM:    n_state = B_DIV;
            B_DIV: begin
                if (w_div_last) n_state = B_DONE;
            end
            B_DONE: begin
                if (w_out_free) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_ws  <= i_frame.wsum;
                r_sr  <= i_frame.sr;
                r_den <= DEN_W'(i_frame.msum) * DEN_W'(FRAME_BINS);
            end
            B_MUL_LO: r_plo <= w_prod;
            B_MUL_HI: r_phi <= w_prod;
            B_SUM: begin
                r_rem <= w_n[N_W-1:OUT_W];
                r_nlo <= w_n[OUT_W-1:0];
                r_cnt <= '0;
            end
            B_DIV: begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                r_nlo <= {r_nlo[OUT_W-2:0], 1'b0};
                r_q   <= {r_q[OUT_W-2:0], w_ge};
                r_cnt <= r_cnt + DCNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == B_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Silent frame: zero divisor gives zero
    always_ff @(posedge i_clk) begin
        if (r_state == B_DONE && w_out_free) begin
            r_out <= (r_den == '0) ? '0 : r_q;
        end
    end

endmodule

FILE: rtl/spectral_centroid_frame.sv
// Top level of the spectral centroid frame block.
// Depends on scf_pkg, scf_front, scf_fifo and scf_back.
//
// Input channel: one magnitude word per bin (i_in_valid / o_in_stall), in bin
// order, FRAME_BINS bins per frame. Output channel: one centroid word per frame
// (o_out_valid / i_out_stall), in 1/16 Hz, zero for a silent frame.
// Config channel: i_cfg_valid / o_cfg_ready writes the sample rate; it is
// always ready and the value is sampled at each frame end.
// Throughput: one bin per cycle while the queue is not full. Each frame's sums go
// into a two-entry queue; the back end takes one frame at a time (scaling on one
// 18x18 multiplier, 22 restoring division steps, one output load).
// When the receiver stalls, the queue fills and
// o_in_stall rises until a frame leaves; the result word holds while stalled.
// Reset (synchronous, active low) clears the bin counter, sums, queue and
// output valid, and sets the sample rate to 44100.
module spectral_centroid_frame (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [scf_pkg::MAG_W-1:0] i_magnitude,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [scf_pkg::OUT_W-1:0] o_centroid_hz,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [scf_pkg::SR_W-1:0]  i_cfg_data
);
    import scf_pkg::*;

    t_frame    w_push_frame;
    t_frame    w_pop_frame;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    scf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_magnitude (i_magnitude),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_frame     (w_push_frame)
    );

    scf_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wdata  (w_push_frame),
        .i_pop    (w_pop),
        .o_rdata  (w_pop_frame),
        .o_status (w_q_status)
    );

    scf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (w_pop_frame),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_centroid_hz (o_centroid_hz)
    );

endmodule

FILE: tb/spectral_centroid_frame_test.sv
// Self-checking testbench for spectral_centroid_frame: whole frames of bins in, centroid words out.
// Depends on scf_pkg and the RTL of spectral_centroid_frame; a scoreboard class predicts each word.
`timescale 1ns / 100ps

module spectral_centroid_frame_test;
    import scf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int          SETTLE_CYC  = 40;      // settle time for the back end
    localparam int          LONG_HOLD   = 8000;    // enough to back up several frames

    typedef enum int {
        SHAPE_SILENT,
        SHAPE_FULL,
        SHAPE_FIRST,
        SHAPE_LAST,
        SHAPE_ONE_LSB,
        SHAPE_UNIFORM,
        SHAPE_SPARSE,
        SHAPE_LOW,
        SHAPE_HIGH
    } t_shape;

    class centroid_scoreboard;
        logic [SR_W-1:0]   rate;
        logic [BIN_W-1:0]  bin;
        logic [MSUM_W-1:0] msum;
        logic [WSUM_W-1:0] wsum;
        logic [OUT_W-1:0]  centroid_q[$];
        int                errors;

        function new();
            rate   = SR_RESET;
            bin    = '0;
            msum   = '0;
            wsum   = '0;
            errors = 0;
        endfunction

        function void set_rate(logic [SR_W-1:0] value);
            rate = value;
        endfunction

        function int pending();
            return centroid_q.size();
        endfunction

        function logic [OUT_W-1:0] frame_centroid();
            logic [63:0] num;
            logic [63:0] den;
            den = 64'(msum) * 64'(FRAME_BINS);
            if (den == 0) begin
                return '0;
            end
            num = 64'(wsum) * 64'(rate) * 64'd16;
            return OUT_W'(num / den);
        endfunction

        // Fold one accepted bin into the running sums; close the frame on its last bin.
        function void note_magnitude(logic [MAG_W-1:0] mag);
            msum = msum + MSUM_W'(mag);
            wsum = wsum + WSUM_W'(64'(bin) * 64'(mag));
            if (bin == LAST_BIN) begin
                centroid_q.push_back(frame_centroid());
                bin  = '0;
                msum = '0;
                wsum = '0;
            end else begin
                bin = bin + 1'b1;
            end
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_centroid(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (centroid_q.size() == 0) begin
                report($sformatf("centroid word 0x%0h with no frame pending", got));
            end else begin
                want = centroid_q.pop_front();
                if (got !== want) begin
                    report($sformatf("centroid_hz got 0x%0h want 0x%0h", got, want));
                end
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [MAG_W-1:0]  i_magnitude;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [OUT_W-1:0]  o_centroid_hz;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SR_W-1:0]   i_cfg_data;

    centroid_scoreboard sb = new();
    bit                 idling_on    = 1'b1;
    bit                 hold_request = 1'b0;
    int unsigned        cycle_count  = 0;

    spectral_centroid_frame DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_magnitude   (i_magnitude),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_centroid_hz (o_centroid_hz),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("spectral_centroid_frame regression: fail");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            i_out_stall = (stall_left != 0);
            if (stall_left != 0) begin
                stall_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_centroid(o_centroid_hz);
        end
    end

    function automatic logic [MAG_W-1:0] bin_magnitude(t_shape shape, int idx);
        case (shape)
            SHAPE_SILENT:  return '0;
            SHAPE_FULL:    return '1;
            SHAPE_FIRST:   return (idx == 0) ? '1 : '0;
            SHAPE_LAST:    return (idx == int'(LAST_BIN)) ? '1 : '0;
            SHAPE_ONE_LSB: return (idx == FRAME_BINS / 2) ? MAG_W'(1) : '0;
            SHAPE_UNIFORM: return MAG_W'($urandom);
            SHAPE_SPARSE:  return ($urandom_range(0, 15) == 0) ? MAG_W'($urandom) : '0;
            SHAPE_LOW:     return MAG_W'($urandom_range(0, 3));
            default:       return MAG_W'($urandom_range(16'hF000, 16'hFFFF));
        endcase
    endfunction

    task automatic send_bin(logic [MAG_W-1:0] mag);
        int gap;
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 9) == 0) begin
            gap        = $urandom_range(1, 12);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_magnitude = mag;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_magnitude(mag);
    endtask

    task automatic send_bins(t_shape shape, int first_bin, int last_bin);
        for (int idx = first_bin; idx <= last_bin; idx++) begin
            send_bin(bin_magnitude(shape, idx));
        end
    endtask

    task automatic send_frame(t_shape shape);
        send_bins(shape, 0, FRAME_BINS - 1);
    endtask

    // Drop valid, wait for every pending word, then let the back end settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [SR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_rate(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [SR_W-1:0] pick_rate();
        case ($urandom_range(0, 7))
            0:       return SR_W'(1);
            1:       return SR_W'(192000);
            2:       return '1;
            default: return SR_W'($urandom_range(1, 192000));
        endcase
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_magnitude = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames at the reset sample rate
        send_frame(SHAPE_SILENT);
        send_frame(SHAPE_FULL);
        send_frame(SHAPE_FIRST);
        send_frame(SHAPE_LAST);
        drain();

        write_rate(SR_W'(192000));
        send_frame(SHAPE_LAST);
        send_frame(SHAPE_FULL);
        send_frame(SHAPE_UNIFORM);
        drain();

        // Zero rate must give zero even for a loud frame
        write_rate('0);
        send_frame(SHAPE_UNIFORM);
        send_frame(SHAPE_LAST);
        drain();

        // All-ones rate lies above 192000, the highest other rate the bench writes
        write_rate('1);
        send_frame(SHAPE_LAST);
        send_frame(SHAPE_FULL);
        send_frame(SHAPE_UNIFORM);
        drain();

        write_rate(SR_W'(1));
        send_frame(SHAPE_LAST);
        send_frame(SHAPE_ONE_LSB);
        send_frame(SHAPE_UNIFORM);
        drain();

        // Rate changed mid-frame applies at that frame's end
        write_rate(SR_W'(48000));
        send_bins(SHAPE_UNIFORM, 0, FRAME_BINS / 2);
        drain();
        write_rate(SR_W'(96000));
        send_bins(SHAPE_UNIFORM, FRAME_BINS / 2 + 1, FRAME_BINS - 1);
        drain();

        // Random frames in rounds, a fresh rate per round
        for (int round = 0; round < 6; round++) begin
            write_rate(pick_rate());
            if (round == 2) begin
                hold_request = 1'b1;   // back up the queue while bins keep coming
            end
            for (int f = 0; f < 6; f++) begin
                send_frame(t_shape'($urandom_range(SHAPE_SILENT, SHAPE_HIGH)));
            end
            drain();
        end

        // Closing stretch with no idling on either side
        idling_on = 1'b0;
        write_rate(pick_rate());
        for (int f = 0; f < 3; f++) begin
            send_frame(t_shape'($urandom_range(SHAPE_UNIFORM, SHAPE_HIGH)));
        end
        drain();

        if (sb.errors == 0) begin
            $display("spectral_centroid_frame regression: pass");
        end else begin
            $display("spectral_centroid_frame regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/scf_pkg.sv
rtl/scf_front.sv
rtl/scf_fifo.sv
rtl/scf_back.sv
rtl/spectral_centroid_frame.sv
tb/spectral_centroid_frame_test.sv
